@@ rtl/mpsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mpsm_pkg;

  // default sizing
  localparam int MAX_NODES_DEF = 256;
  localparam int MAX_IDS_DEF   = 64;
  localparam int ALPHABET_DEF  = 26;
  localparam int ID_BITS_DEF   = 16;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int LETTER_W = 5;
  localparam int POS_W    = 16;
  localparam int STATUS_W = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PLETTER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PEND    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_MATCH = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LATE  = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_PL_UPD, S_PE_LINK, S_LATE, S_FULL,
    S_BR_RD, S_BR_CHK, S_B_POP, S_B_CUR, S_B_F, S_B_CH_RD, S_B_VIA_RD,
    S_B_UPD, S_T_START, S_T_GOTO, S_T_HEAD, S_T_LIST, S_T_ID, S_T_FAIL,
    S_T_FLUSH
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_DROP, OP_SINGLE_LATE, OP_SINGLE_FULL, OP_PL_RD,
    OP_PL_UPD, OP_PE_WR, OP_PE_LINK, OP_BR_INIT, OP_BR_RD, OP_BR_CHK,
    OP_BQ_POP, OP_B_CUR, OP_B_F, OP_B_CH_RD, OP_B_VIA_RD, OP_B_UPD,
    OP_BUILT, OP_T_START, OP_T_GOTO, OP_T_HEAD, OP_T_ID_RD, OP_T_ID,
    OP_T_FAIL_RD, OP_T_FAIL, OP_T_FLUSH
  } dp_op_t;

  typedef struct packed {
    logic clr_done;
    logic kind_pl;
    logic kind_pe;
    logic kind_text;
    logic built;
    logic dropped;
    logic letter_ok;
    logic ids_full;
    logic queue_empty;
    logic i_last;
    logic e_empty;
    logic walk_root;
    logic pend;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/mpsm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mpsm_ctrl import mpsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  dp_status_t st,
  output dp_op_t     op,
  output logic       in_stall
);

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath command
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_stall   = (state != S_IDLE);
    case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        if (st.kind_pl) begin
          if (st.built) state_next = S_LATE;
          else if (st.dropped) state_next = S_IDLE;
          else if (!st.letter_ok) op = OP_DROP;
          else begin
            op = OP_PL_RD;
            state_next = S_PL_UPD;
          end
        end else if (st.kind_pe) begin
          if (st.built) state_next = S_LATE;
          else if (st.dropped || st.ids_full) state_next = S_FULL;
          else begin
            op = OP_PE_WR;
            state_next = S_PE_LINK;
          end
        end else if (st.kind_text) begin
          if (st.built) state_next = S_T_START;
          else begin
            op = OP_BR_INIT;
            state_next = S_BR_RD;
          end
        end
      end
      S_PL_UPD: begin
        op = OP_PL_UPD;
        state_next = S_IDLE;
      end
      S_PE_LINK: begin
        op = OP_PE_LINK;
        state_next = S_IDLE;
      end
      S_LATE: begin
        if (st.out_free) begin
          op = OP_SINGLE_LATE;
          state_next = S_IDLE;
        end
      end
      S_FULL: begin
        if (st.out_free) begin
          op = OP_SINGLE_FULL;
          state_next = S_IDLE;
        end
      end
      // build: root children first
      S_BR_RD: begin
        op = OP_BR_RD;
        state_next = S_BR_CHK;
      end
      S_BR_CHK: begin
        op = OP_BR_CHK;
        state_next = st.i_last ? S_B_POP : S_BR_RD;
      end
      // build: breadth first over the queue
      S_B_POP: begin
        if (st.queue_empty) begin
          op = OP_BUILT;
          state_next = S_T_START;
        end else begin
          op = OP_BQ_POP;
          state_next = S_B_CUR;
        end
      end
      S_B_CUR: begin
        op = OP_B_CUR;
        state_next = S_B_F;
      end
      S_B_F: begin
        op = OP_B_F;
        state_next = S_B_CH_RD;
      end
      S_B_CH_RD: begin
        op = OP_B_CH_RD;
        state_next = S_B_VIA_RD;
      end
      S_B_VIA_RD: begin
        op = OP_B_VIA_RD;
        state_next = S_B_UPD;
      end
      S_B_UPD: begin
        op = OP_B_UPD;
        state_next = st.i_last ? S_B_POP : S_B_CH_RD;
      end
      // search step and match walk
      S_T_START: begin
        op = OP_T_START;
        state_next = S_T_GOTO;
      end
      S_T_GOTO: begin
        op = OP_T_GOTO;
        state_next = S_T_HEAD;
      end
      S_T_HEAD: begin
        op = OP_T_HEAD;
        state_next = S_T_LIST;
      end
      S_T_LIST: begin
        if (!st.e_empty) begin
          op = OP_T_ID_RD;
          state_next = S_T_ID;
        end else if (st.walk_root) begin
          state_next = S_T_FLUSH;
        end else begin
          op = OP_T_FAIL_RD;
          state_next = S_T_FAIL;
        end
      end
      S_T_ID: begin
        if (!st.pend || st.out_free) begin
          op = OP_T_ID;
          state_next = S_T_LIST;
        end
      end
      S_T_FAIL: begin
        op = OP_T_FAIL;
        state_next = S_T_HEAD;
      end
      S_T_FLUSH: begin
        if (!st.pend) state_next = S_IDLE;
        else if (st.out_free) begin
          op = OP_T_FLUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/mpsm_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mpsm_dp import mpsm_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_IDS   = MAX_IDS_DEF,
  parameter int ALPHABET  = ALPHABET_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_op_t              op,
  output dp_status_t          st,
  input  logic                accept,
  input  logic [KIND_W-1:0]   kind,
  input  logic [LETTER_W-1:0] letter,
  input  logic [ID_BITS-1:0]  pattern_id,
  input  logic                text_start,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [STATUS_W-1:0] status,
  output logic [ID_BITS-1:0]  match_id,
  output logic [POS_W-1:0]    position,
  output logic                last
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int LW    = $clog2(ALPHABET);
  localparam int GW    = NW + LW;
  localparam int IW    = $clog2(MAX_IDS + 1);
  localparam int IAW   = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int NDEP  = 1 << NW;
  localparam int GDEP  = 1 << GW;
  localparam logic [IW-1:0] NO_ID  = IW'(MAX_IDS);
  localparam logic [LW-1:0] I_LAST = LW'(ALPHABET - 1);

  // latched request
  logic [KIND_W-1:0]   kind_q;
  logic [LETTER_W-1:0] letter_q;
  logic [ID_BITS-1:0]  pid_q;
  logic                ts_q;

  // automaton registers
  logic [NW-1:0]    ins_cursor, search_node, cur, f, ch, walk;
  logic [NW:0]      nodes_used, head_idx, tail_idx;
  logic [IW-1:0]    ids_used, e;
  logic             built, dropped, pend;
  logic [LW-1:0]    i;
  logic [GW-1:0]    clr;
  logic [POS_W-1:0] text_pos, pos_q;
  logic [ID_BITS-1:0] pend_id;

  // memories
  logic [NW-1:0]      goto_mem  [GDEP];
  logic [NW-1:0]      fail_mem  [NDEP];
  logic [2*IW-1:0]    own_mem   [NDEP];
  logic [ID_BITS-1:0] idv_mem   [MAX_IDS];
  logic [IW-1:0]      idn_mem   [MAX_IDS];
  logic [NW-1:0]      queue_mem [NDEP];
  logic [NW-1:0]      gq, fq, qq;
  logic [2*IW-1:0]    own_q;
  logic [ID_BITS-1:0] idv_q;
  logic [IW-1:0]      idn_q;

  logic [LW-1:0] lidx;
  logic [NW-1:0] sn_eff, node_sel;
  logic [IW-1:0] own_head, own_tail;
  logic letter_ok, nodes_full, tail_ok, clr_row;

  assign lidx       = LW'(letter_q);
  assign letter_ok  = 32'(letter_q) < ALPHABET;
  assign sn_eff     = ts_q ? '0 : search_node;
  assign node_sel   = letter_ok ? gq : '0;
  assign own_head   = own_q[2*IW-1:IW];
  assign own_tail   = own_q[IW-1:0];
  assign nodes_full = nodes_used >= (NW+1)'(MAX_NODES);
  assign tail_ok    = tail_idx < (NW+1)'(MAX_NODES);
  assign clr_row    = (clr[LW-1:0] == '0);

  // goto port control
  logic g_re, g_we;
  logic [GW-1:0] g_ra, g_wa;
  logic [NW-1:0] g_wd;
  always_comb begin
    g_re = 1'b0; g_ra = '0; g_we = 1'b0; g_wa = '0; g_wd = '0;
    case (op)
      OP_CLEAR: begin
        g_we = 1'b1; g_wa = clr;
      end
      OP_PL_RD: begin
        g_re = 1'b1; g_ra = {ins_cursor, lidx};
      end
      OP_PL_UPD: begin
        g_we = (gq == '0) && !nodes_full;
        g_wa = {ins_cursor, lidx};
        g_wd = nodes_used[NW-1:0];
      end
      OP_BR_RD: begin
        g_re = 1'b1; g_ra = {{NW{1'b0}}, i};
      end
      OP_B_CH_RD: begin
        g_re = 1'b1; g_ra = {cur, i};
      end
      OP_B_VIA_RD: begin
        g_re = 1'b1; g_ra = {f, i};
      end
      OP_B_UPD: begin
        g_we = (ch == '0); g_wa = {cur, i}; g_wd = gq;
      end
      OP_T_START: begin
        g_re = 1'b1; g_ra = {sn_eff, lidx};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (g_we) goto_mem[g_wa] <= g_wd;
    if (g_re) gq <= goto_mem[g_ra];
  end

  // failure link port control
  logic f_re, f_we;
  logic [NW-1:0] f_ra, f_wa, f_wd;
  always_comb begin
    f_re = 1'b0; f_ra = '0; f_we = 1'b0; f_wa = '0; f_wd = '0;
    case (op)
      OP_CLEAR: begin
        f_we = clr_row; f_wa = clr[GW-1:LW];
      end
      OP_BR_CHK: begin
        f_we = (gq != '0); f_wa = gq;
      end
      OP_B_UPD: begin
        f_we = (ch != '0); f_wa = ch; f_wd = gq;
      end
      OP_B_CUR: begin
        f_re = 1'b1; f_ra = qq;
      end
      OP_T_FAIL_RD: begin
        f_re = 1'b1; f_ra = walk;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (f_we) fail_mem[f_wa] <= f_wd;
    if (f_re) fq <= fail_mem[f_ra];
  end

  // own id list head and tail per node
  logic o_re, o_we;
  logic [NW-1:0] o_ra, o_wa;
  logic [2*IW-1:0] o_wd;
  always_comb begin
    o_re = 1'b0; o_ra = '0; o_we = 1'b0; o_wa = '0; o_wd = '0;
    case (op)
      OP_CLEAR: begin
        o_we = clr_row; o_wa = clr[GW-1:LW]; o_wd = {NO_ID, NO_ID};
      end
      OP_PE_WR: begin
        o_re = 1'b1; o_ra = ins_cursor;
      end
      OP_PE_LINK: begin
        o_we = 1'b1; o_wa = ins_cursor;
        o_wd = {(own_head == NO_ID) ? ids_used : own_head, ids_used};
      end
      OP_T_GOTO: begin
        o_re = 1'b1; o_ra = node_sel;
      end
      OP_T_FAIL: begin
        o_re = 1'b1; o_ra = fq;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (o_we) own_mem[o_wa] <= o_wd;
    if (o_re) own_q <= own_mem[o_ra];
  end

  // id value and next-link stores
  logic n_we;
  logic [IAW-1:0] n_wa;
  logic [IW-1:0] n_wd;
  always_comb begin
    n_we = 1'b0; n_wa = '0; n_wd = '0;
    case (op)
      OP_PE_WR: begin
        n_we = 1'b1; n_wa = ids_used[IAW-1:0]; n_wd = NO_ID;
      end
      OP_PE_LINK: begin
        n_we = (own_head != NO_ID); n_wa = own_tail[IAW-1:0]; n_wd = ids_used;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (op == OP_PE_WR) idv_mem[ids_used[IAW-1:0]] <= pid_q;
    if (n_we) idn_mem[n_wa] <= n_wd;
    if (op == OP_T_ID_RD) begin
      idv_q <= idv_mem[e[IAW-1:0]];
      idn_q <= idn_mem[e[IAW-1:0]];
    end
  end

  // breadth-first queue
  logic q_we;
  logic [NW-1:0] q_wd;
  always_comb begin
    q_we = 1'b0; q_wd = '0;
    case (op)
      OP_BR_CHK: begin
        q_we = (gq != '0) && tail_ok; q_wd = gq;
      end
      OP_B_UPD: begin
        q_we = (ch != '0) && tail_ok; q_wd = ch;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[tail_idx[NW-1:0]] <= q_wd;
    if (op == OP_BQ_POP) qq <= queue_mem[head_idx[NW-1:0]];
  end

  // result emission
  logic emit, emit_last;
  logic [STATUS_W-1:0] emit_status;
  always_comb begin
    emit = 1'b0; emit_last = 1'b1; emit_status = ST_MATCH;
    case (op)
      OP_SINGLE_LATE: begin
        emit = 1'b1; emit_status = ST_LATE;
      end
      OP_SINGLE_FULL: begin
        emit = 1'b1; emit_status = ST_FULL;
      end
      OP_T_ID: begin
        emit = pend; emit_last = 1'b0;
      end
      OP_T_FLUSH: emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status   <= emit_status;
      match_id <= (emit_status == ST_MATCH) ? pend_id : '0;
      position <= (emit_status == ST_MATCH) ? pos_q : '0;
      last     <= emit_last;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= kind;
      letter_q <= letter;
      pid_q    <= pattern_id;
      ts_q     <= text_start;
    end
  end

  // scratch registers of build and walk
  always_ff @(posedge clk) begin
    case (op)
      OP_B_CUR:    cur     <= qq;
      OP_B_F:      f       <= fq;
      OP_B_VIA_RD: ch      <= gq;
      OP_T_START:  pos_q   <= ts_q ? '0 : text_pos;
      OP_T_GOTO:   walk    <= node_sel;
      OP_T_FAIL:   walk    <= fq;
      OP_T_HEAD:   e       <= own_head;
      OP_T_ID: begin
        pend_id <= idv_q;
        e       <= idn_q;
      end
      default: ;
    endcase
    if (op == OP_BR_INIT || op == OP_B_F) i <= '0;
    else if (op == OP_BR_CHK || op == OP_B_UPD) i <= i + 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr         <= '0;
      ins_cursor  <= '0;
      search_node <= '0;
      nodes_used  <= (NW+1)'(1);
      ids_used    <= '0;
      built       <= 1'b0;
      dropped     <= 1'b0;
      text_pos    <= '0;
      pend        <= 1'b0;
      head_idx    <= '0;
      tail_idx    <= '0;
      out_valid   <= 1'b0;
    end else begin
      // output slot: load on emit, free once taken
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (op)
        OP_CLEAR: clr <= clr + 1'b1;
        OP_DROP: dropped <= 1'b1;
        OP_SINGLE_FULL: begin
          dropped    <= 1'b0;
          ins_cursor <= '0;
        end
        OP_PL_UPD: begin
          if (gq != '0) ins_cursor <= gq;
          else if (nodes_full) dropped <= 1'b1;
          else begin
            ins_cursor <= nodes_used[NW-1:0];
            nodes_used <= nodes_used + 1'b1;
          end
        end
        OP_PE_LINK: begin
          ins_cursor <= '0;
          ids_used   <= ids_used + 1'b1;
        end
        OP_BR_INIT: begin
          head_idx <= '0;
          tail_idx <= '0;
        end
        OP_BR_CHK: if (gq != '0 && tail_ok) tail_idx <= tail_idx + 1'b1;
        OP_B_UPD:  if (ch != '0 && tail_ok) tail_idx <= tail_idx + 1'b1;
        OP_BQ_POP: head_idx <= head_idx + 1'b1;
        OP_BUILT:  built <= 1'b1;
        OP_T_START: begin
          pend <= 1'b0;
          if (ts_q) text_pos <= POS_W'(1);
          else if (text_pos != '1) text_pos <= text_pos + 1'b1;
        end
        OP_T_GOTO:  search_node <= node_sel;
        OP_T_ID:    pend <= 1'b1;
        OP_T_FLUSH: pend <= 1'b0;
        default: ;
      endcase
    end
  end

  // status to controller
  always_comb begin
    st.clr_done    = (clr == '1);
    st.kind_pl     = (kind_q == KIND_PLETTER);
    st.kind_pe     = (kind_q == KIND_PEND);
    st.kind_text   = (kind_q == KIND_TEXT);
    st.built       = built;
    st.dropped     = dropped;
    st.letter_ok   = letter_ok;
    st.ids_full    = (ids_used >= IW'(MAX_IDS));
    st.queue_empty = (head_idx == tail_idx);
    st.i_last      = (i == I_LAST);
    st.e_empty     = (e >= NO_ID);
    st.walk_root   = (walk == '0);
    st.pend        = pend;
    st.out_free    = !out_valid || !out_stall;
  end

  // node count stays within the store and includes the root
  a_nodes_range: assert property (@(posedge clk) disable iff (rst)
    (nodes_used != '0) && (nodes_used <= (NW+1)'(MAX_NODES)))
    else $error("node count out of range");

  a_ids_range: assert property (@(posedge clk) disable iff (rst)
    ids_used <= IW'(MAX_IDS))
    else $error("id count out of range");

  // the automaton is built once and stays built
  a_built_sticky: assert property (@(posedge clk) disable iff (rst)
    built |=> built)
    else $error("built flag dropped");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    head_idx <= tail_idx)
    else $error("queue read past write");

  // a result is only loaded while the output slot can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || !out_stall))
    else $error("result overwritten");

endmodule
`default_nettype wire

@@ rtl/multi_pattern_string_matcher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Aho-Corasick matcher over a letter alphabet. After reset a clearing pass
// writes every goto entry once, while in_stall stays high. Each pattern
// letter and pattern end is bound by one read-modify-write of a single-port
// store; a letter of a dropped pattern skips the store. The first text letter
// first runs the build pass, paced by the one read port of the goto store. A
// text letter then takes its goto step and reports the ids of its node and of
// each failure link followed, waiting on out_stall when needed; results of one
// request come out in order, last marking the final one, and a letter with no
// match gives no result.
module multi_pattern_string_matcher import mpsm_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_IDS   = MAX_IDS_DEF,
  parameter int ALPHABET  = ALPHABET_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [LETTER_W-1:0] letter,
  input  logic [ID_BITS-1:0]  pattern_id,
  input  logic                text_start,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [ID_BITS-1:0]  match_id,
  output logic [POS_W-1:0]    position,
  output logic                last
);

  dp_op_t     op;
  dp_status_t st;
  logic       accept;

  assign accept = in_valid && !in_stall;

  // sequencer
  mpsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .st       (st),
    .op       (op),
    .in_stall (in_stall)
  );

  // stores and registers
  mpsm_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_IDS   (MAX_IDS),
    .ALPHABET  (ALPHABET),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .st         (st),
    .accept     (accept),
    .kind       (kind),
    .letter     (letter),
    .pattern_id (pattern_id),
    .text_start (text_start),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .status     (status),
    .match_id   (match_id),
    .position   (position),
    .last       (last)
  );

endmodule
`default_nettype wire

@@ test/multi_pattern_string_matcher_test.sv @@
`timescale 1ns / 1ps
module multi_pattern_string_matcher_test;
  import mpsm_pkg::*;

  localparam int NODES  = MAX_NODES_DEF;
  localparam int IDS    = MAX_IDS_DEF;
  localparam int LETTERS = ALPHABET_DEF;
  localparam int NO_ID  = IDS;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [15:0]         id;
    logic [15:0]         pos;
    logic                lst;
  } match_t;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [LETTER_W-1:0] ltr;
    logic [15:0]         pid;
    logic                start;
    bit                  has_exp;
    logic [STATUS_W-1:0] exp_st;
  } req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [LETTER_W-1:0] letter = '0;
  logic [15:0] pattern_id = '0;
  logic text_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [15:0] match_id;
  logic [POS_W-1:0] position;
  logic last;

  multi_pattern_string_matcher u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .letter(letter), .pattern_id(pattern_id), .text_start(text_start),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .match_id(match_id), .position(position), .last(last)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // automaton mirror
  int unsigned trie_next [NODES*LETTERS];
  int unsigned fail_of [NODES];
  int unsigned id_head [NODES];
  int unsigned id_tail [NODES];
  int unsigned id_val [IDS];
  int unsigned id_link [IDS];
  int unsigned node_count, id_count, cursor, walk_node, text_pos;
  bit built, dropping;

  match_t expected_matches[$];
  match_t step_out[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int idle_mode = 0;
  int n_full = 0, n_late = 0, n_match = 0;

  function automatic void trie_reset();
    for (int i = 0; i < NODES*LETTERS; i++) trie_next[i] = 0;
    for (int i = 0; i < NODES; i++) begin
      fail_of[i] = 0;
      id_head[i] = NO_ID;
      id_tail[i] = NO_ID;
    end
    node_count = 1;
    id_count = 0;
    cursor = 0;
    walk_node = 0;
    text_pos = 0;
    built = 0;
    dropping = 0;
  endfunction

  // breadth-first pass: failure links and filled-in transitions
  function automatic void build_links();
    int unsigned fifo[$];
    int unsigned cur, f, ch, via;
    for (int c = 0; c < LETTERS; c++) begin
      if (trie_next[c] != 0) begin
        fail_of[trie_next[c]] = 0;
        fifo = {fifo, trie_next[c]};
      end
    end
    while (fifo.size() > 0) begin
      cur = fifo.pop_front();
      f = fail_of[cur];
      for (int i = 0; i < LETTERS; i++) begin
        ch = trie_next[cur*LETTERS + i];
        via = trie_next[f*LETTERS + i];
        if (ch != 0) begin
          fail_of[ch] = via;
          fifo = {fifo, ch};
        end else begin
          trie_next[cur*LETTERS + i] = via;
        end
      end
    end
    built = 1;
  endfunction

  function automatic void single_status(logic [STATUS_W-1:0] st);
    match_t m;
    m = '{st: st, id: 16'd0, pos: 16'd0, lst: 1'b1};
    step_out = {step_out, m};
  endfunction

  // expected results of one request, into step_out
  function automatic void predict_matches(req_t r);
    int unsigned ch, node, pos, e, v;
    match_t m;
    step_out.delete();
    if (r.kind == KIND_PLETTER) begin
      if (built) single_status(ST_LATE);
      else if (!dropping) begin
        if (r.ltr >= LETTERS) dropping = 1;
        else begin
          ch = trie_next[cursor*LETTERS + r.ltr];
          if (ch == 0) begin
            if (node_count >= NODES) dropping = 1;
            else begin
              ch = node_count++;
              trie_next[cursor*LETTERS + r.ltr] = ch;
            end
          end
          if (!dropping) cursor = ch;
        end
      end
    end else if (r.kind == KIND_PEND) begin
      if (built) single_status(ST_LATE);
      else if (dropping || id_count >= IDS) begin
        dropping = 0;
        cursor = 0;
        single_status(ST_FULL);
      end else begin
        v = id_count++;
        id_val[v] = r.pid;
        id_link[v] = NO_ID;
        if (id_head[cursor] == NO_ID) id_head[cursor] = v;
        else id_link[id_tail[cursor]] = v;
        id_tail[cursor] = v;
        cursor = 0;
      end
    end else if (r.kind == KIND_TEXT) begin
      if (!built) build_links();
      if (r.start) begin
        walk_node = 0;
        text_pos = 0;
      end
      node = (r.ltr < LETTERS) ? trie_next[walk_node*LETTERS + r.ltr] : 0;
      walk_node = node;
      pos = text_pos;
      if (text_pos < 16'hFFFF) text_pos++;
      for (int steps = 0; steps < NODES; steps++) begin
        e = id_head[node];
        while (e < IDS && step_out.size() < 64) begin
          m = '{st: ST_MATCH, id: id_val[e][15:0], pos: pos[15:0], lst: 1'b0};
          step_out = {step_out, m};
          e = id_link[e];
        end
        if (node == 0) break;
        node = fail_of[node];
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].lst = 1'b1;
    end
  endfunction

  function automatic int sender_pct();
    return (idle_mode == 1) ? 52 : (idle_mode == 3) ? 17 : 0;
  endfunction

  // one request through the input handshake, then prediction
  task automatic send_request(req_t r);
    int gap;
    match_t m;
    idle_mode = (sent / 40) % 4;
    gap = 0;
    while ($urandom_range(99) < sender_pct() && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind <= r.kind;
    letter <= r.ltr;
    pattern_id <= r.pid;
    text_start <= r.start;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    predict_matches(r);
    if (r.has_exp) begin
      step_out.delete();
      m = '{st: r.exp_st, id: 16'd0, pos: 16'd0, lst: 1'b1};
      step_out = {step_out, m};
    end
    expected_matches = {expected_matches, step_out};
  endtask

  task automatic send_fields(logic [KIND_W-1:0] k, logic [LETTER_W-1:0] l,
                             logic [15:0] p, logic s);
    req_t r;
    r = '{kind: k, ltr: l, pid: p, start: s, has_exp: 0, exp_st: ST_MATCH};
    send_request(r);
  endtask

  // receiver stall
  always @(posedge clk) begin
    if (idle_mode == 2) out_stall <= ($urandom_range(99) < 52);
    else if (idle_mode == 3) out_stall <= ($urandom_range(99) < 17);
    else out_stall <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    match_t want;
    if (!rst && out_valid && !out_stall) begin
      received++;
      if (expected_matches.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status=%0d id=%h pos=%0d last=%b",
                   status, match_id, position, last);
      end else begin
        want = expected_matches.pop_front();
        case (want.st)
          ST_MATCH: n_match++;
          ST_FULL:  n_full++;
          default:  n_late++;
        endcase
        if (status !== want.st || match_id !== want.id || position !== want.pos ||
            last !== want.lst) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected st=%0d id=%h pos=%0d last=%b, got st=%0d id=%h pos=%0d last=%b",
                     want.st, want.id, want.pos, want.lst,
                     status, match_id, position, last);
        end
      end
    end
  end

  // directed pattern loading
  req_t load_table[] = '{
    '{KIND_UNUSED,  5'd7,  16'h0000, 1'b1, 0, ST_MATCH},
    '{KIND_PEND,    5'd0,  16'hFFFF, 1'b0, 0, ST_MATCH},
    '{KIND_PLETTER, 5'd0,  16'h0000, 1'b0, 0, ST_MATCH},
    '{KIND_PEND,    5'd0,  16'h0001, 1'b0, 0, ST_MATCH},
    '{KIND_PLETTER, 5'd0,  16'hFFFF, 1'b1, 0, ST_MATCH},
    '{KIND_PLETTER, 5'd1,  16'h0000, 1'b0, 0, ST_MATCH},
    '{KIND_PEND,    5'd31, 16'h8000, 1'b1, 0, ST_MATCH},
    '{KIND_PLETTER, 5'd1,  16'h0000, 1'b0, 0, ST_MATCH},
    '{KIND_PEND,    5'd0,  16'h0002, 1'b0, 0, ST_MATCH},
    '{KIND_PLETTER, 5'd25, 16'h0000, 1'b0, 0, ST_MATCH},
    '{KIND_PLETTER, 5'd25, 16'h0000, 1'b0, 0, ST_MATCH},
    '{KIND_PEND,    5'd0,  16'h0003, 1'b0, 0, ST_MATCH},
    // letter beyond z drops the pattern
    '{KIND_PLETTER, 5'd31, 16'h0000, 1'b0, 0, ST_MATCH},
    '{KIND_PLETTER, 5'd0,  16'h0000, 1'b0, 0, ST_MATCH},
    '{KIND_PEND,    5'd0,  16'h0004, 1'b0, 1, ST_FULL},
    '{KIND_PLETTER, 5'd26, 16'h0000, 1'b0, 0, ST_MATCH},
    '{KIND_PEND,    5'd0,  16'h0005, 1'b0, 1, ST_FULL},
    // second id on the root and a repeated pattern
    '{KIND_PEND,    5'd0,  16'h1234, 1'b0, 0, ST_MATCH},
    '{KIND_PLETTER, 5'd0,  16'h0000, 1'b0, 0, ST_MATCH},
    '{KIND_PEND,    5'd0,  16'h00FF, 1'b0, 0, ST_MATCH}
  };

  initial begin
    int plen, drain;
    bit is_long;
    trie_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (load_table[i]) send_request(load_table[i]);

    // random pattern loading: many very short patterns to pile up ids, a few
    // long ones to run the node store out
    for (int p = 0; p < 64; p++) begin
      is_long = (p % 8 == 0);
      plen = is_long ? $urandom_range(34, 31) : $urandom_range(1, 0);
      for (int j = 0; j < plen; j++) begin
        if (!is_long && $urandom_range(9) == 0)
          send_fields(KIND_PLETTER, LETTER_W'($urandom_range(31, 26)),
                      16'($urandom), 1'($urandom));
        else if ($urandom_range(29) == 0)
          send_fields(KIND_UNUSED, LETTER_W'($urandom), 16'($urandom), 1'($urandom));
        else
          send_fields(KIND_PLETTER,
                      LETTER_W'(is_long ? $urandom_range(25) : $urandom_range(2)),
                      16'($urandom), 1'($urandom));
      end
      send_fields(KIND_PEND, LETTER_W'($urandom), 16'($urandom), 1'($urandom));
    end

    // hold off until the load results have drained
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_matches.size() != 0) @(posedge clk);

    // text: first letter without a text start, then random texts
    send_fields(KIND_TEXT, 5'd0, 16'($urandom), 1'b0);
    for (int t = 0; t < 30; t++) begin
      case ($urandom_range(19))
        0: send_fields(KIND_UNUSED, LETTER_W'($urandom), 16'($urandom), 1'($urandom));
        1: send_fields(KIND_W'($urandom_range(1)), LETTER_W'($urandom), 16'($urandom),
                       1'($urandom));
        2: send_fields(KIND_TEXT, LETTER_W'($urandom_range(31, 26)), 16'($urandom),
                       ($urandom_range(9) == 0));
        3, 4, 5: send_fields(KIND_TEXT, LETTER_W'($urandom_range(25)), 16'($urandom),
                             ($urandom_range(9) == 0));
        default: send_fields(KIND_TEXT, LETTER_W'($urandom_range(2)), 16'($urandom),
                             ($urandom_range(9) == 0));
      endcase
    end
    in_valid <= 1'b0;

    while (expected_matches.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 2000) begin
      @(posedge clk);
      drain++;
    end

    $display("sent %0d requests over %0d nodes and %0d ids", sent, node_count, id_count);
    $display("checked %0d results: %0d matches, %0d store full, %0d late inserts",
             received, n_match, n_full, n_late);
    if (errors == 0 && expected_matches.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_matches.size());
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("timeout with %0d results outstanding", expected_matches.size());
    $display("FAILURE");
    $finish;
  end

endmodule
